// File: design/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, register indexes and controller interface types for the
// lidar scan statistics block.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int MAX_SAMPLES = 4096;

    // Field widths
    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 20;
    localparam int STEP_W   = 24;
    localparam int COS_W    = 16;
    localparam int OUT_ANG_W = 32;
    localparam int COUNT_W  = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Sample indexing
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int SIDX_W = $clog2(MAX_SAMPLES + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd4;

    // Shared wide multiplier: 32 x 16
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Join test width: (a^2+b^2)<<15 against (g^2<<15) + 2ab*c
    localparam int SQ_W   = 2 * RANGE_W;
    localparam int JOIN_W = MUL_P_W + 2;

    // Angle offset: (index * step + 500) / 1000
    localparam int PROD_W   = IDX_W + STEP_W;
    localparam int DIVD_W   = PROD_W + 1;
    localparam int ANG_DIV  = 1000;
    localparam int ANG_RND  = ANG_DIV / 2;

    // Divide by 1000: D = hi*2^18 + lo = hi*262*1000 + (hi*144 + lo); the
    // folded part goes through a reciprocal multiply (1000 = 8 * 125)
    localparam int DIV_LO_W   = 18;
    localparam int DIV_HI_W   = DIVD_W - DIV_LO_W;
    localparam int DIV_HI_MUL = (1 << DIV_LO_W) / ANG_DIV;
    localparam int DIV_LO_MUL = (1 << DIV_LO_W) % ANG_DIV;
    localparam int DIV_Z_W    = 27;
    localparam int DIV_Q_W    = 28;
    localparam int RCP_PRE    = 3;
    localparam int RCP_Y_W    = DIV_Z_W - RCP_PRE;
    localparam int RCP_SHIFT  = 30;
    localparam int RCP_W      = 24;
    localparam int RCP_P_W    = RCP_Y_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << (RCP_SHIFT + RCP_PRE)) + ANG_DIV - 1) / ANG_DIV);

    typedef struct packed {
        logic capture;
        logic mul_step;
        logic sum_step;
        logic update;
        logic ang_mul;
        logic div_start;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last;
        logic div_busy;
        logic out_free;
    } t_ctrl_status;

endpackage

// File: design/lss_div_const.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_div_const
// Divider by the constant ANG_DIV: split and fold, then a reciprocal multiply.
// Start registers the fold, then the reciprocal product, then the quotient.
// ----------------------------------------------------------------------------
module lss_div_const import lss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    output logic              o_busy,
    output logic [DIVD_W-1:0] o_quotient
);

    logic [DIV_HI_W-1:0] w_hi;
    logic [DIV_LO_W-1:0] w_lo;
    logic [DIV_Z_W-1:0]  w_fold;
    logic [DIV_Q_W-1:0]  w_hi_quo;

    logic                r_stage1;
    logic                r_stage2;
    logic [DIV_Q_W-1:0]  r_hi_quo;
    logic [DIV_Z_W-1:0]  r_fold;
    logic [RCP_P_W-1:0]  r_prod;
    logic [DIV_Q_W-1:0]  r_quo;

    assign w_hi     = i_dividend[DIVD_W-1:DIV_LO_W];
    assign w_lo     = i_dividend[DIV_LO_W-1:0];
    assign w_fold   = DIV_Z_W'(w_hi) * DIV_Z_W'(DIV_LO_MUL) + DIV_Z_W'(w_lo);
    assign w_hi_quo = DIV_Q_W'(w_hi) * DIV_Q_W'(DIV_HI_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_stage2 <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_stage2 <= r_stage1;
        end
    end

    // folded part stays below 2^27, so the reciprocal floor is exact
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi_quo <= w_hi_quo;
            r_fold   <= w_fold;
        end
        if (r_stage1) begin
            r_prod <= r_fold[DIV_Z_W-1:RCP_PRE] * RCP_MUL;
        end
        if (r_stage2) begin
            r_quo <= r_hi_quo + DIV_Q_W'(r_prod[RCP_P_W-1:RCP_SHIFT]);
        end
    end

    assign o_busy     = r_stage1 || r_stage2;
    assign o_quotient = DIVD_W'(r_quo);

endmodule

// File: design/lss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_datapath
// Configuration registers, scan accumulators, join test arithmetic, angle
// computation and the result register.
// ----------------------------------------------------------------------------
module lss_datapath import lss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_status          o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [RANGE_W-1:0]    i_range_mm,
    input  logic                  i_not_finite,
    input  logic                  i_last_sample,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [RANGE_W-1:0]    o_min_range_mm,
    output logic [OUT_ANG_W-1:0]  o_min_angle_mdeg,
    output logic [COUNT_W-1:0]    o_valid_readings,
    output logic [COUNT_W-1:0]    o_segment_total,
    output logic                  o_min_found
);

    // Configuration
    logic [RANGE_W-1:0] r_range_max;
    logic [ANGLE_W-1:0] r_angle_min;
    logic [STEP_W-1:0]  r_angle_step;
    logic [COS_W-1:0]   r_cos_step;
    logic [RANGE_W-1:0] r_gap;
    logic [SQ_W-1:0]    r_gap_sq;

    // Captured request
    logic [RANGE_W-1:0] r_in_range;
    logic               r_in_finite;
    logic               r_in_last;

    // Scan state
    logic [RANGE_W-1:0] r_best_range;
    logic [IDX_W-1:0]   r_best_index;
    logic [SIDX_W-1:0]  r_sample_index;
    logic [COUNT_W-1:0] r_valid_count;
    logic [COUNT_W-1:0] r_segment_count;
    logic               r_in_segment;
    logic [RANGE_W-1:0] r_prev_range;
    logic               r_prev_ok;
    logic               r_any_finite;

    // Arithmetic
    logic [SQ_W-1:0]    r_ab;
    logic [SQ_W-1:0]    r_dd;
    logic [MUL_P_W-1:0] r_wide;
    logic [JOIN_W-1:0]  r_lhs;

    logic [RANGE_W-1:0] w_diff;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_mul_p;
    logic [JOIN_W-1:0]  w_rhs;
    logic               w_join;
    logic               w_in_window;
    logic [DIVD_W-1:0]  w_dividend;
    logic [DIVD_W-1:0]  w_quotient;
    logic               w_div_busy;
    logic [OUT_ANG_W-1:0] w_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_max  <= 16'hFFFF;
            r_angle_min  <= ANGLE_W'(-180000);
            r_angle_step <= STEP_W'(1000000);
            r_cos_step   <= COS_W'(32763);
            r_gap        <= RANGE_W'(300);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RANGE_MAX:  r_range_max  <= i_cfg_data[RANGE_W-1:0];
                CFG_ANGLE_MIN:  r_angle_min  <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_STEP: r_angle_step <= i_cfg_data[STEP_W-1:0];
                CFG_COS_STEP:   r_cos_step   <= i_cfg_data[COS_W-1:0];
                CFG_GAP:        r_gap        <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // gap^2 tracks the register; settles long before any join test reads it
    always_ff @(posedge i_clk) begin
        r_gap_sq <= r_gap * r_gap;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_range  <= i_range_mm;
            r_in_finite <= ~i_not_finite;
            r_in_last   <= i_last_sample;
        end
    end

    // a^2 + b^2 = (a-b)^2 + 2ab
    assign w_diff = (r_prev_range > r_in_range) ? r_prev_range - r_in_range
                                                : r_in_range - r_prev_range;

    // shared 32x16 multiplier: ab*cos during the join test, index*step at scan end
    assign w_mul_a = i_cmd.ang_mul ? MUL_A_W'(r_angle_step) : r_ab;
    assign w_mul_b = i_cmd.ang_mul ? MUL_B_W'(r_best_index) : r_cos_step;
    assign w_mul_p = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_step) begin
            r_ab <= r_prev_range * r_in_range;
            r_dd <= w_diff * w_diff;
        end
        if (i_cmd.sum_step) begin
            r_lhs <= JOIN_W'({(SQ_W+1)'(r_dd) + {r_ab, 1'b0}, 15'b0});
        end
        if (i_cmd.sum_step || i_cmd.ang_mul) begin
            r_wide <= w_mul_p;
        end
    end

    assign w_rhs  = JOIN_W'({r_gap_sq, 15'b0}) + JOIN_W'({r_wide, 1'b0});
    assign w_join = r_lhs < w_rhs;
    assign w_in_window = r_sample_index < SIDX_W'(MAX_SAMPLES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_best_range    <= '1;
            r_best_index    <= '0;
            r_sample_index  <= '0;
            r_valid_count   <= '0;
            r_segment_count <= '0;
            r_in_segment    <= 1'b0;
            r_prev_range    <= '0;
            r_prev_ok       <= 1'b0;
            r_any_finite    <= 1'b0;
        end else if (i_cmd.update && w_in_window) begin
            if (r_in_finite) begin
                // earliest sample keeps an equal minimum
                if (!r_any_finite || r_in_range < r_best_range) begin
                    r_best_range <= r_in_range;
                    r_best_index <= r_sample_index[IDX_W-1:0];
                end
                r_any_finite <= 1'b1;
                if (r_in_range != r_range_max && r_valid_count != COUNT_MAX) begin
                    r_valid_count <= r_valid_count + 1'b1;
                end
            end
            if (r_sample_index != '0) begin
                if (r_in_finite && r_prev_ok && w_join) begin
                    if (!r_in_segment) begin
                        r_in_segment <= 1'b1;
                        if (r_segment_count != COUNT_MAX) begin
                            r_segment_count <= r_segment_count + 1'b1;
                        end
                    end
                end else begin
                    r_in_segment <= 1'b0;
                end
            end
            r_prev_range   <= r_in_range;
            r_prev_ok      <= r_in_finite;
            r_sample_index <= r_sample_index + 1'b1;
        end
    end

    assign w_dividend = DIVD_W'(r_wide[PROD_W-1:0]) + DIVD_W'(ANG_RND);

    lss_div_const u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    assign w_angle = OUT_ANG_W'($signed(r_angle_min)) + OUT_ANG_W'(w_quotient);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_min_range_mm   <= r_any_finite ? r_best_range : '0;
            o_min_angle_mdeg <= r_any_finite ? w_angle : '0;
            o_valid_readings <= r_valid_count;
            o_segment_total  <= r_segment_count;
            o_min_found      <= r_any_finite;
        end
    end

    assign o_status.last     = r_in_last;
    assign o_status.div_busy = w_div_busy;
    assign o_status.out_free = !o_out_valid || !i_out_stall;

endmodule

// File: design/lss_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_controller
// Sequencer: accepts a sample, steps the join test, folds the sample into
// the scan, and on the last sample runs the angle computation and result load.
// ----------------------------------------------------------------------------
module lss_controller import lss_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_SUM  = 8'b0000_0100,
        S_UPD  = 8'b0000_1000,
        S_ANG  = 8'b0001_0000,
        S_DIVS = 8'b0010_0000,
        S_DIVW = 8'b0100_0000,
        S_LOAD = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                n_state        = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.last ? S_ANG : S_IDLE;
            end
            S_ANG: begin
                o_cmd.ang_mul = 1'b1;
                n_state       = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (!i_status.div_busy) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // hold until the result register can take the new result
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: design/lidar_scan_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_statistics
// Per-scan nearest obstacle, valid reading count and segment count.
// ----------------------------------------------------------------------------
// Each sample is accepted, then steps through the join test (range products,
// the 32x16 cosine multiply with the left-hand sum, then the compare and
// scan update). A sample marked last adds a multiply of index by step, a
// divide by 1000 (a start state, then the fold and reciprocal multiply), and
// the result load. The result sits in an output register, so the next scan
// starts while it waits to be taken; a later last sample holds only if that
// register is still full. The user must write configuration only while the
// block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lidar_scan_statistics import lss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [RANGE_W-1:0]    i_range_mm,
    input  logic                  i_not_finite,
    input  logic                  i_last_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [RANGE_W-1:0]    o_min_range_mm,
    output logic [OUT_ANG_W-1:0]  o_min_angle_mdeg,
    output logic [COUNT_W-1:0]    o_valid_readings,
    output logic [COUNT_W-1:0]    o_segment_total,
    output logic                  o_min_found
);

    t_ctrl_cmd    w_cmd;
    t_ctrl_status w_status;

    lss_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lss_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_range_mm       (i_range_mm),
        .i_not_finite     (i_not_finite),
        .i_last_sample    (i_last_sample),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_min_range_mm   (o_min_range_mm),
        .o_min_angle_mdeg (o_min_angle_mdeg),
        .o_valid_readings (o_valid_readings),
        .o_segment_total  (o_segment_total),
        .o_min_found      (o_min_found)
    );

endmodule

// File: design/lss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_checker
// Port-level checks for lidar_scan_statistics, attached by bind.
// ----------------------------------------------------------------------------
module lss_checker import lss_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [RANGE_W-1:0]    o_min_range_mm,
    input logic [OUT_ANG_W-1:0]  o_min_angle_mdeg,
    input logic [COUNT_W-1:0]    o_valid_readings,
    input logic [COUNT_W-1:0]    o_segment_total,
    input logic                  o_min_found
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_min_range_mm)
            && $stable(o_min_angle_mdeg) && $stable(o_valid_readings)
            && $stable(o_segment_total) && $stable(o_min_found))
        else $error("result changed while stalled");

    // an accepted request keeps the input side busy for its processing
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a new result only comes out of a busy sequencer
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // an empty scan reports zeros everywhere
    a_empty_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_min_found |-> o_min_range_mm == '0
            && o_min_angle_mdeg == '0 && o_valid_readings == '0
            && o_segment_total == '0)
        else $error("empty scan with nonzero fields");

endmodule

bind lidar_scan_statistics lss_checker u_lss_checker (.*);
